### rtl/core/ocl_pkg.sv
// ----------------------------------------------------------------------------
// ocl_pkg
// shared constants and types for the optimal replacement cache directory
// ----------------------------------------------------------------------------
package ocl_pkg;

  localparam int SETS       = 16;
  localparam int WAYS       = 32;
  localparam int BYTE_SEL_W = 6;

  localparam int ADDR_W    = 64;
  localparam int NU_W      = 32;
  localparam int CNT_W     = 48;
  localparam int WAY_OUT_W = 5;

  // sets is a power of two: set index and tag are a plain bit split
  localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int TAG_BITS = ADDR_W - BYTE_SEL_W - SET_BITS;
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int IN_TDATA_W  = ((ADDR_W + NU_W + 7) / 8) * 8;
  localparam int OUT_RAW_W   = 1 + WAY_OUT_W + 1 + 2 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [SET_BITS-1:0] set_idx_t;
  typedef logic [WAY_BITS-1:0] way_idx_t;

  typedef struct packed {
    logic            valid;
    logic            dead;
    logic [NU_W-1:0] reuse;
    tag_t            tag;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic     hit;
    logic     replaced;
    way_idx_t way;
  } sel_t;

endpackage

### rtl/core/optimal_replacement_cache_lookup.sv
// ----------------------------------------------------------------------------
// optimal_replacement_cache_lookup
// set-associative cache directory with optimal (farthest reuse) replacement
// ----------------------------------------------------------------------------
// an accepted word passes set read, select and write back in turn; output stalls hold it in write back
// a new word is taken only once the previous one has been written back
// the set row memory has one read and one write port; one access in flight
// reset: per-set valid flags and hit/miss counts clear at once, no sweep
// ----------------------------------------------------------------------------
module optimal_replacement_cache_lookup (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // address, next use time
  input  logic [ocl_pkg::IN_TDATA_W-1:0]      in_tdata,
  // never_again
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // hit, way_used, replaced, hit_total, miss_total, zero pad
  output logic [ocl_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [ocl_pkg::SETS-1:0]      row_valid_r, row_valid_nxt;
  logic [ocl_pkg::CNT_W-1:0]     hit_cnt_r, hit_cnt_nxt;
  logic [ocl_pkg::CNT_W-1:0]     miss_cnt_r, miss_cnt_nxt;
  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [ocl_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  ocl_pkg::tag_t                 tag_r;
  ocl_pkg::set_idx_t             set_r;
  logic [ocl_pkg::NU_W-1:0]      nu_r;
  logic                          dead_r;
  ocl_pkg::sel_t                 sel_r;

  logic                          in_acc;
  logic                          out_free;
  logic                          wb_go;
  logic [ocl_pkg::ADDR_W-1:0]    in_addr;
  ocl_pkg::set_idx_t             in_set;
  ocl_pkg::tag_t                 in_tag;
  logic [ocl_pkg::ROW_W-1:0]     rdata;
  ocl_pkg::row_t                 row_eff;
  ocl_pkg::row_t                 row_new;
  ocl_pkg::sel_t                 sel;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign wb_go     = (state_r == ST_WB) && out_free;

  assign in_addr = in_tdata[ocl_pkg::ADDR_W-1:0];
  assign in_set  = in_addr[ocl_pkg::BYTE_SEL_W +: ocl_pkg::SET_BITS];
  assign in_tag  = in_addr[ocl_pkg::ADDR_W-1 -: ocl_pkg::TAG_BITS];

  ocl_ram #(
    .WIDTH(ocl_pkg::ROW_W),
    .DEPTH(ocl_pkg::SETS)
  ) u_row_ram (
    .clk  (clk),
    .we   (wb_go),
    .waddr(set_r),
    .wdata(row_new),
    .re   (in_acc),
    .raddr(in_set),
    .rdata(rdata)
  );

  // a set never written reads as all lines empty
  always_comb begin
    row_eff = ocl_pkg::row_t'(rdata);
    for (int w = 0; w < ocl_pkg::WAYS; w++) begin
      row_eff[w].valid = row_eff[w].valid && row_valid_r[set_r];
    end
  end

  ocl_select u_select (
    .row(row_eff),
    .tag(tag_r),
    .sel(sel)
  );

  always_comb begin
    row_new = row_eff;
    row_new[sel_r.way].reuse = nu_r;
    row_new[sel_r.way].dead  = dead_r;
    if (!sel_r.hit) begin
      row_new[sel_r.way].valid = 1'b1;
      row_new[sel_r.way].tag   = tag_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    row_valid_nxt  = row_valid_r;
    hit_cnt_nxt    = hit_cnt_r;
    miss_cnt_nxt   = miss_cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (out_free) begin
          state_nxt             = ST_IDLE;
          row_valid_nxt[set_r]  = 1'b1;
          out_tvalid_nxt        = 1'b1;
          if (sel_r.hit) begin
            if (hit_cnt_r != ocl_pkg::CNT_MAX) begin
              hit_cnt_nxt = hit_cnt_r + 1'b1;
            end
          end else begin
            if (miss_cnt_r != ocl_pkg::CNT_MAX) begin
              miss_cnt_nxt = miss_cnt_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      row_valid_r  <= '0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_valid_r  <= row_valid_nxt;
      hit_cnt_r    <= hit_cnt_nxt;
      miss_cnt_r   <= miss_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_r  <= in_tag;
      set_r  <= in_set;
      nu_r   <= in_tdata[ocl_pkg::ADDR_W +: ocl_pkg::NU_W];
      dead_r <= in_tuser;
    end
    if (state_r == ST_RD) begin
      sel_r <= sel;
    end
    if (wb_go) begin
      out_tdata_r <= ocl_pkg::OUT_TDATA_W'({miss_cnt_nxt, hit_cnt_nxt, sel_r.replaced,
                                           ocl_pkg::WAY_OUT_W'(sel_r.way), sel_r.hit});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### rtl/core/ocl_ram.sv
// ----------------------------------------------------------------------------
// ocl_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module ocl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/ocl_select.sv
// ----------------------------------------------------------------------------
// ocl_select
// tag match, fill way search and optimal victim choice over one set
// ----------------------------------------------------------------------------
module ocl_select (
  input  ocl_pkg::row_t row,
  input  ocl_pkg::tag_t tag,
  output ocl_pkg::sel_t sel
);

  always_comb begin
    logic [ocl_pkg::WAYS-1:0]     match;
    logic [ocl_pkg::WAYS-1:0]     empty;
    logic [ocl_pkg::WAYS-1:0]     dead;
    ocl_pkg::way_idx_t            match_idx;
    ocl_pkg::way_idx_t            empty_idx;
    ocl_pkg::way_idx_t            dead_idx;
    logic [ocl_pkg::NU_W-1:0]     val [ocl_pkg::WAYS];
    ocl_pkg::way_idx_t            idx [ocl_pkg::WAYS];

    match_idx = '0;
    empty_idx = '0;
    dead_idx  = '0;
    for (int w = 0; w < ocl_pkg::WAYS; w++) begin
      match[w] = row[w].valid && (row[w].tag == tag);
      empty[w] = !row[w].valid;
      dead[w]  = row[w].dead;
      val[w]   = row[w].reuse;
      idx[w]   = ocl_pkg::WAY_BITS'(w);
    end
    for (int w = ocl_pkg::WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        match_idx = ocl_pkg::WAY_BITS'(w);
      end
      if (empty[w]) begin
        empty_idx = ocl_pkg::WAY_BITS'(w);
      end
      if (dead[w]) begin
        dead_idx = ocl_pkg::WAY_BITS'(w);
      end
    end
    // max tree, lower way keeps ties
    for (int s = 1; s < ocl_pkg::WAYS; s = s * 2) begin
      for (int i = 0; i + s < ocl_pkg::WAYS; i = i + 2 * s) begin
        if (val[i+s] > val[i]) begin
          val[i] = val[i+s];
          idx[i] = idx[i+s];
        end
      end
    end

    sel.hit      = |match;
    sel.replaced = 1'b0;
    if (|match) begin
      sel.way = match_idx;
    end else if (|empty) begin
      sel.way = empty_idx;
    end else begin
      sel.replaced = 1'b1;
      sel.way      = (|dead) ? dead_idx : idx[0];
    end
  end

endmodule

### rtl/core/ocl_checker.sv
// ----------------------------------------------------------------------------
// ocl_checker
// port-level checks for the optimal replacement cache directory
// ----------------------------------------------------------------------------
module ocl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ocl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one lookup in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while lookup in flight");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[ocl_pkg::WAY_OUT_W + 1]))
    else $error("hit reported with eviction");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind optimal_replacement_cache_lookup ocl_checker u_ocl_checker (.*);

### tb/tb_optimal_replacement_cache_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_optimal_replacement_cache_lookup
// self-checking bench for the optimal replacement cache directory: drives
// lookup words with random gaps, predicts hit, way, eviction and both counts
// from a shadow directory, and checks every result word in order under
// random and long back-pressure
// ----------------------------------------------------------------------------
module tb_optimal_replacement_cache_lookup;

  localparam int LINES       = ocl_pkg::SETS * ocl_pkg::WAYS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HITS_LSB    = 1 + ocl_pkg::WAY_OUT_W + 1;
  localparam int MISSES_LSB  = HITS_LSB + ocl_pkg::CNT_W;

  typedef struct {
    logic                          hit;
    logic [ocl_pkg::WAY_OUT_W-1:0] way;
    logic                          replaced;
    logic [ocl_pkg::CNT_W-1:0]     hits;
    logic [ocl_pkg::CNT_W-1:0]     misses;
  } lookup_res_t;

  logic                            clk;
  logic                            rst_n     = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ocl_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                            in_tuser  = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ocl_pkg::OUT_TDATA_W-1:0] out_tdata;

  optimal_replacement_cache_lookup dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow directory
  bit                        dir_valid [LINES];
  logic [63:0]               dir_tag   [LINES];
  logic [ocl_pkg::NU_W-1:0]  dir_reuse [LINES];
  bit                        dir_dead  [LINES];
  logic [ocl_pkg::CNT_W-1:0] dir_hits   = '0;
  logic [ocl_pkg::CNT_W-1:0] dir_misses = '0;

  lookup_res_t expected_q[$];

  int errors        = 0;
  int cycle_count   = 0;
  int send_gap_max  = 0;
  int stall_max     = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int stall_left    = 0;

  function automatic lookup_res_t predict_lookup(input logic [63:0] addr,
                                                 input logic [ocl_pkg::NU_W-1:0] nu,
                                                 input logic dead);
    logic [63:0]              blk;
    logic [63:0]              tag;
    int                       base;
    int                       way;
    bit                       hit;
    bit                       repl;
    logic [ocl_pkg::NU_W-1:0] best;
    lookup_res_t              r;
    blk  = addr >> ocl_pkg::BYTE_SEL_W;
    tag  = blk / ocl_pkg::SETS;
    base = int'(blk % ocl_pkg::SETS) * ocl_pkg::WAYS;
    way  = -1;
    hit  = 1'b0;
    repl = 1'b0;
    for (int w = 0; w < ocl_pkg::WAYS && way < 0; w++) begin
      if (dir_valid[base + w] && dir_tag[base + w] == tag) begin
        way = w;
        hit = 1'b1;
      end
    end
    if (hit) begin
      if (dir_hits != ocl_pkg::CNT_MAX) dir_hits = dir_hits + 1'b1;
    end else begin
      if (dir_misses != ocl_pkg::CNT_MAX) dir_misses = dir_misses + 1'b1;
      for (int w = 0; w < ocl_pkg::WAYS && way < 0; w++) begin
        if (!dir_valid[base + w]) way = w;
      end
      if (way < 0) begin
        repl = 1'b1;
        for (int w = 0; w < ocl_pkg::WAYS && way < 0; w++) begin
          if (dir_dead[base + w]) way = w;
        end
        if (way < 0) begin
          // strictly larger wins, so the lowest way keeps a tie
          way  = 0;
          best = dir_reuse[base];
          for (int w = 1; w < ocl_pkg::WAYS; w++) begin
            if (dir_reuse[base + w] > best) begin
              best = dir_reuse[base + w];
              way  = w;
            end
          end
        end
      end
      dir_valid[base + way] = 1'b1;
      dir_tag[base + way]   = tag;
    end
    dir_reuse[base + way] = nu;
    dir_dead[base + way]  = dead;
    r.hit      = hit;
    r.way      = ocl_pkg::WAY_OUT_W'(way);
    r.replaced = repl;
    r.hits     = dir_hits;
    r.misses   = dir_misses;
    return r;
  endfunction

  function automatic logic [63:0] make_addr(input logic [63:0] tag, input int set_i);
    logic [63:0] offs;
    logic [63:0] mask;
    offs = {$urandom, $urandom};
    mask = (64'd1 << ocl_pkg::BYTE_SEL_W) - 64'd1;
    return ((tag * ocl_pkg::SETS + 64'(set_i)) << ocl_pkg::BYTE_SEL_W) | (offs & mask);
  endfunction

  // result checking
  always @(posedge clk) begin : check_results
    lookup_res_t got;
    lookup_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit      = out_tdata[0];
      got.way      = out_tdata[1 +: ocl_pkg::WAY_OUT_W];
      got.replaced = out_tdata[1 + ocl_pkg::WAY_OUT_W];
      got.hits     = out_tdata[HITS_LSB +: ocl_pkg::CNT_W];
      got.misses   = out_tdata[MISSES_LSB +: ocl_pkg::CNT_W];
      if (expected_q.size() == 0) begin
        $error("result word with no lookup pending");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, got.hit);
          errors++;
        end
        if (got.way !== want.way) begin
          $error("way_used: expected %0d, got %0d", want.way, got.way);
          errors++;
        end
        if (got.replaced !== want.replaced) begin
          $error("replaced: expected %0d, got %0d", want.replaced, got.replaced);
          errors++;
        end
        if (got.hits !== want.hits) begin
          $error("hit_total: expected %0d, got %0d", want.hits, got.hits);
          errors++;
        end
        if (got.misses !== want.misses) begin
          $error("miss_total: expected %0d, got %0d", want.misses, got.misses);
          errors++;
        end
      end
    end
  end

  // result side ready, with per-word stalls and long hold-offs
  always @(posedge clk) begin : result_ready
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (out_tvalid && out_tready) stall_left = $urandom_range(0, stall_max);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_optimal_replacement_cache_lookup failed");
      $finish;
    end
  end

  task automatic send_lookup(input logic [63:0] addr, input logic [ocl_pkg::NU_W-1:0] nu,
                             input logic dead);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {nu, addr};
    in_tuser  <= dead;
    expected_q = {expected_q, predict_lookup(addr, nu, dead)};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ocl_pkg::NU_W-1:0] draw_reuse();
    case ($urandom_range(0, 3))
      0:       return ocl_pkg::NU_W'($urandom_range(0, 7));
      1:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_address_extremes();
    send_gap_max = 0;
    stall_max    = 0;
    send_lookup(64'h0, 32'h0, 1'b0);
    send_lookup(64'h0, 32'hFFFF_FFFF, 1'b0);
    send_lookup(64'h3F, 32'h1, 1'b1);
    send_lookup(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_lookup(64'hFFFF_FFFF_FFFF_FFC0, 32'h0, 1'b0);
    send_lookup(64'h40, 32'h5555_5555, 1'b0);
    send_lookup(64'h400, 32'hAAAA_AAAA, 1'b0);
    send_lookup(64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1);
    send_lookup(64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_lookup(64'h8000_0000_0000_0000, 32'h1234_5678, 1'b0);
    send_lookup(64'h0000_0000_0000_0400, 32'h0, 1'b1);
    send_lookup(64'h5555_5555_5555_5555, 32'h0000_FFFF, 1'b0);
    send_lookup(64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_0000, 1'b1);
    wait_drained();
  endtask

  // fill one set, then walk the victim order: dead line first, lowest of a
  // tied maximum, strict maximum, and a hit that marks its line dead
  task automatic test_victim_choice();
    int set_i;
    set_i        = 5;
    send_gap_max = 3;
    stall_max    = 3;
    for (int w = 0; w < ocl_pkg::WAYS; w++) begin
      send_lookup(make_addr(64'h100 + w, set_i), (w == 3 || w == 7) ? 32'd500 : 32'd100,
                  w == 20);
    end
    send_lookup(make_addr(64'h200, set_i), 32'd10, 1'b0);
    send_lookup(make_addr(64'h201, set_i), 32'd10, 1'b0);
    send_lookup(make_addr(64'h202, set_i), 32'd10, 1'b0);
    send_lookup(make_addr(64'h109, set_i), 32'd10, 1'b1);
    send_lookup(make_addr(64'h203, set_i), 32'd10, 1'b0);
    send_lookup(make_addr(64'h204, set_i), 32'hFFFF_FFFF, 1'b0);
    send_lookup(make_addr(64'h205, set_i), 32'd0, 1'b0);
    send_lookup(make_addr(64'h204, set_i), 32'd0, 1'b0);
    wait_drained();
  endtask

  // bursts on one set at a time from a small tag pool, so that hits, fills
  // and evictions all occur
  task automatic test_set_thrash(input int items);
    logic [63:0] pool [48];
    int          pool_size;
    int          burst;
    int          set_i;
    int          done;
    done = 0;
    while (done < items) begin
      set_i     = $urandom_range(0, ocl_pkg::SETS - 1);
      pool_size = $urandom_range(20, 48);
      burst     = $urandom_range(40, 120);
      for (int i = 0; i < pool_size; i++) begin
        pool[i] = {$urandom, $urandom} >> (64 - ocl_pkg::TAG_BITS);
      end
      case ($urandom_range(0, 3))
        0:       begin send_gap_max = 0;  stall_max = 0;  end
        1:       begin send_gap_max = 16; stall_max = 16; end
        default: begin send_gap_max = $urandom_range(0, 16); stall_max = $urandom_range(0, 16); end
      endcase
      for (int i = 0; i < burst; i++) begin
        send_lookup(make_addr(pool[$urandom_range(0, pool_size - 1)], set_i), draw_reuse(),
                    $urandom_range(0, 7) == 0);
      end
      done += burst;
    end
    stop_sending();
  endtask

  task automatic test_random_addresses(input int items);
    send_gap_max = 16;
    stall_max    = 16;
    for (int i = 0; i < items; i++) begin
      send_lookup({$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)));
    end
    stop_sending();
  endtask

  task automatic test_output_hold_off();
    send_gap_max = 0;
    stall_max    = 0;
    hold_request = 200;
    for (int i = 0; i < 40; i++) begin
      send_lookup(make_addr(64'($urandom_range(0, 40)), $urandom_range(0, 1)),
                  draw_reuse(), $urandom_range(0, 7) == 0);
    end
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_gap_max = 2;
    stall_max    = 8;
    for (int i = 0; i < 30; i++) begin
      send_lookup(make_addr(64'($urandom_range(0, 40)), 9), draw_reuse(), 1'b0);
    end
    wait_drained();
    for (int i = 0; i < 30; i++) begin
      send_lookup(make_addr(64'($urandom_range(0, 40)), 9), draw_reuse(),
                  $urandom_range(0, 3) == 0);
    end
    stop_sending();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_address_extremes();
    test_victim_choice();
    test_output_hold_off();
    test_set_thrash(1100);
    test_drain_pause();
    test_random_addresses(200);
    test_set_thrash(250);
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_optimal_replacement_cache_lookup passed");
    end else begin
      $display("tb_optimal_replacement_cache_lookup failed");
    end
    $finish;
  end

endmodule
